// ===== sv/marker_framed_packet_parser_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Marker framed packet parser assertion macros
// Concurrent assertion wrappers, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef MARKER_FRAMED_PACKET_PARSER_UNIT_ASSERT_SVH
`define MARKER_FRAMED_PACKET_PARSER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
`define MFPP_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define MFPP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define MFPP_ASSERT(lbl, prop, msg)
`define MFPP_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ===== sv/mfpp_pkg.sv =====
// ----------------------------------------------------------------------------
// Marker framed packet parser package
// Framing constants, register indexes, flag codes and shared types.
// ----------------------------------------------------------------------------
`default_nettype none

package mfpp_pkg;

	localparam int PACKET_BYTES   = 75;
	localparam int MARKER_BYTES   = 2;
	localparam int SAMPLE_BYTES   = 64;
	localparam int EVT_SHIFT      = 2;
	localparam int TRIG_SHIFT     = 12;

	localparam int HDR_OFS    = MARKER_BYTES;
	localparam int SAMPLE_OFS = HDR_OFS + 7;
	localparam int MK_W       = 8 * MARKER_BYTES;
	localparam int CNT_W      = $clog2(PACKET_BYTES);
	localparam int IDX_W      = $clog2(SAMPLE_BYTES);

	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(PACKET_BYTES - 1);
	localparam logic [15:0]      PKT_WRAP = 16'hFFFE;

	localparam logic [1:0] FLAG_RESYNC   = 2'b01;
	localparam logic [1:0] FLAG_NO_START = 2'b10;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] CFG_CHECK_EN      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_START_MARKER  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_STOP_MARKER   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_CHAN_MASK     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_CHAN_SHIFT    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_ABS_WIND_MASK = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_EVT_WIND_MASK = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_TIMING_MASK   = 3'd7;

	typedef logic [7:0] byte_t;

	typedef struct packed {
		logic [7:0]  channel;
		logic [31:0] trig_time;
		logic [15:0] log_win;
		logic [7:0]  phys_win;
		logic [1:0]  info_flags;
		logic [15:0] packet_number;
	} hdr_t;

	typedef struct packed {
		logic load;
		hdr_t hdr;
	} emit_t;

endpackage

`default_nettype wire

// ===== sv/mfpp_cell.sv =====
// ----------------------------------------------------------------------------
// Byte cell
// One byte of a shift chain: parallel load or take the neighbour's byte.
// ----------------------------------------------------------------------------
`default_nettype none

module mfpp_cell
	import mfpp_pkg::*;
(
	input  wire   clk,
	input  wire   ld,
	input  byte_t ld_byte,
	input  wire   sh,
	input  byte_t sh_byte,
	output byte_t q
);

	byte_t q_q;

	always_ff @(posedge clk) begin
		if (ld) begin
			q_q <= ld_byte;
		end else if (sh) begin
			q_q <= sh_byte;
		end
	end

	assign q = q_q;

endmodule

`default_nettype wire

// ===== sv/mfpp_ctrl.sv =====
// ----------------------------------------------------------------------------
// Framing control
// Configuration registers, marker checks, lock and error tracking, header
// decode and packet numbering.
// ----------------------------------------------------------------------------
`default_nettype none

`include "marker_framed_packet_parser_unit_assert.svh"

module mfpp_ctrl
	import mfpp_pkg::*;
(
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   cfg_wen,
	input  wire [CFG_IDX_W-1:0]   cfg_idx,
	input  wire [CFG_DATA_W-1:0]  cfg_wdata,
	input  wire                   byte_fire,
	input  byte_t                 nw [PACKET_BYTES],
	input  wire                   busy,
	output logic                  byte_ready,
	output emit_t                 emit
);

	logic             check_en_q;
	logic [15:0]      start_marker_q;
	logic [15:0]      stop_marker_q;
	logic [7:0]       chan_mask_q;
	logic [2:0]       chan_shift_q;
	logic [7:0]       abs_wind_mask_q;
	logic [7:0]       evt_wind_mask_q;
	logic [15:0]      timing_mask_q;

	logic [CNT_W-1:0] cnt_q;
	logic [1:0]       err_q;
	logic             locked_q;
	logic [15:0]      pkt_num_q;

	logic [MK_W-1:0]  start_val;
	logic [MK_W-1:0]  stop_val;
	logic             full;
	logic             blind;
	logic             start_ok;
	logic             stop_ok;
	logic             frame;
	logic             do_emit;
	logic [15:0]      w1;
	logic [15:0]      w2;
	byte_t            p0;
	byte_t            p1;
	logic [1:0]       flags;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			check_en_q      <= 1'b1;
			start_marker_q  <= '0;
			stop_marker_q   <= '0;
			chan_mask_q     <= 8'hFF;
			chan_shift_q    <= '0;
			abs_wind_mask_q <= 8'hFF;
			evt_wind_mask_q <= 8'hFF;
			timing_mask_q   <= 16'hFFFF;
		end else if (cfg_wen) begin
			unique case (cfg_idx)
				CFG_CHECK_EN:      check_en_q      <= cfg_wdata[0];
				CFG_START_MARKER:  start_marker_q  <= cfg_wdata[15:0];
				CFG_STOP_MARKER:   stop_marker_q   <= cfg_wdata[15:0];
				CFG_CHAN_MASK:     chan_mask_q     <= cfg_wdata[7:0];
				CFG_CHAN_SHIFT:    chan_shift_q    <= cfg_wdata[2:0];
				CFG_ABS_WIND_MASK: abs_wind_mask_q <= cfg_wdata[7:0];
				CFG_EVT_WIND_MASK: evt_wind_mask_q <= cfg_wdata[7:0];
				CFG_TIMING_MASK:   timing_mask_q   <= cfg_wdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		start_val = '0;
		stop_val  = '0;
		for (int k = 0; k < MARKER_BYTES; k++) begin
			start_val[MK_W-1-8*k -: 8] = nw[k];
			stop_val[MK_W-1-8*k -: 8]  = nw[PACKET_BYTES-MARKER_BYTES+k];
		end
	end

	assign full     = (cnt_q == CNT_FULL);
	assign blind    = !check_en_q && locked_q;
	assign start_ok = (start_val == start_marker_q[MK_W-1:0]);
	assign stop_ok  = (stop_val == stop_marker_q[MK_W-1:0]);
	assign frame    = byte_fire && full;
	assign do_emit  = frame && (blind || stop_ok);

	assign byte_ready = !(busy && full);

	always_comb begin
		if (blind) begin
			flags = '0;
		end else if (start_ok) begin
			flags = err_q;
		end else begin
			flags = err_q | FLAG_NO_START;
		end
	end

	assign w1 = {nw[HDR_OFS+1], nw[HDR_OFS+2]};
	assign w2 = {nw[HDR_OFS+3], nw[HDR_OFS+4]};
	assign p0 = nw[HDR_OFS+5];
	assign p1 = nw[HDR_OFS+6];

	always_comb begin
		emit.load              = do_emit;
		emit.hdr.channel       = (nw[HDR_OFS] >> chan_shift_q) & chan_mask_q;
		emit.hdr.trig_time     = ({16'd0, w1} << TRIG_SHIFT)
		                       | {16'd0, w2 & timing_mask_q};
		emit.hdr.log_win       = ({8'd0, p0 & abs_wind_mask_q} << (8 - EVT_SHIFT))
		                       | {8'd0, (p1 >> EVT_SHIFT) & evt_wind_mask_q};
		emit.hdr.phys_win      = p1 & abs_wind_mask_q;
		emit.hdr.info_flags    = flags;
		emit.hdr.packet_number = pkt_num_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			err_q     <= '0;
			locked_q  <= 1'b0;
			pkt_num_q <= '0;
		end else begin
			if (byte_fire) begin
				if (!full) begin
					cnt_q <= cnt_q + 1'b1;
				end else if (do_emit) begin
					cnt_q <= '0;
				end
			end
			if (frame && !blind) begin
				if (stop_ok) begin
					locked_q <= 1'b1;
					err_q    <= start_ok ? 2'b00 : (err_q | FLAG_NO_START);
				end else begin
					err_q <= err_q | FLAG_RESYNC;
				end
			end
			if (do_emit) begin
				pkt_num_q <= (pkt_num_q == PKT_WRAP) ? 16'd0 : pkt_num_q + 16'd1;
			end
		end
	end

	`MFPP_ASSERT(a_cnt_range, (cnt_q <= CNT_FULL), "byte count beyond window")
	`MFPP_ASSERT_NEXT(a_emit_empties, do_emit, (cnt_q == '0), "window not emptied")
	`MFPP_ASSERT_NEXT(a_slide_keeps, (frame && !do_emit), (cnt_q == CNT_FULL && err_q[0]),
		"slide lost window or resync flag")
	`MFPP_ASSERT(a_stall_cause, (!byte_ready |-> (busy && full)), "spurious input stall")

endmodule

`default_nettype wire

// ===== sv/mfpp_out.sv =====
// ----------------------------------------------------------------------------
// Sample output
// Header hold register and sample byte chain; shift one byte per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

`include "marker_framed_packet_parser_unit_assert.svh"

module mfpp_out
	import mfpp_pkg::*;
(
	input  wire              clk,
	input  wire              arst_n,
	input  emit_t            emit,
	input  byte_t            samples [SAMPLE_BYTES],
	input  wire              result_ready,
	output logic             result_valid,
	output logic             busy,
	output hdr_t             hdr,
	output byte_t            sample_byte,
	output logic [IDX_W-1:0] sample_index,
	output logic             last
);

	logic             busy_q;
	logic [IDX_W-1:0] idx_q;
	hdr_t             hdr_q;
	logic             out_fire;
	byte_t            chain [SAMPLE_BYTES];

	assign out_fire = busy_q && result_ready;

	for (genvar k = 0; k < SAMPLE_BYTES; k++) begin : g_smp
		byte_t nxt;
		if (k < SAMPLE_BYTES - 1) begin : g_mid
			assign nxt = chain[k+1];
		end else begin : g_end
			assign nxt = '0;
		end
		mfpp_cell u_cell (
			.clk     (clk),
			.ld      (emit.load),
			.ld_byte (samples[k]),
			.sh      (out_fire),
			.sh_byte (nxt),
			.q       (chain[k])
		);
	end

	always_ff @(posedge clk) begin
		if (emit.load) begin
			hdr_q <= emit.hdr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else if (emit.load) begin
			busy_q <= 1'b1;
			idx_q  <= '0;
		end else if (out_fire) begin
			idx_q <= idx_q + 1'b1;
			if (last) begin
				busy_q <= 1'b0;
			end
		end
	end

	assign result_valid = busy_q;
	assign busy         = busy_q;
	assign hdr          = hdr_q;
	assign sample_byte  = chain[0];
	assign sample_index = idx_q;
	assign last         = (idx_q == IDX_W'(SAMPLE_BYTES - 1));

	`MFPP_ASSERT(a_load_idle, (emit.load |-> !busy_q), "packet loaded over pending samples")
	`MFPP_ASSERT_NEXT(a_load_start, emit.load, (busy_q && idx_q == '0),
		"packet load did not start emission")
	`MFPP_ASSERT_NEXT(a_last_done, (out_fire && last), !busy_q, "emission ran past last sample")

endmodule

`default_nettype wire

// ===== sv/marker_framed_packet_parser_unit.sv =====
// ----------------------------------------------------------------------------
// Marker framed packet parser
// Start/stop marker deframer: byte window chain, marker checks and
// 64-byte sample emission per packet.
// ----------------------------------------------------------------------------
//  Channel   Handshake                   Payload
//  cfg       cfg_wen                     cfg_idx, cfg_wdata
//  byte      byte_valid / byte_ready     in_byte
//  result    result_valid / result_ready channel, trig_time, log_win, phys_win,
//                                        info_flags, packet_number,
//                                        sample_byte, sample_index, last
//
//  One byte per cycle; a packet is decided in the cycle its final byte transfers.
//  Its 64 results leave one per cycle from the sample chain while result_ready
//  is high, overlapping the next packet's bytes; byte_ready drops only when a
//  window is one byte from full while samples of the previous packet are pending.
//  Reset clears count, flags, lock, pkt number; presets config; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module marker_framed_packet_parser_unit
	import mfpp_pkg::*;
(
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  cfg_wen,
	input  wire [CFG_IDX_W-1:0]  cfg_idx,
	input  wire [CFG_DATA_W-1:0] cfg_wdata,
	input  wire                  byte_valid,
	output logic                 byte_ready,
	input  wire [7:0]            in_byte,
	output logic                 result_valid,
	input  wire                  result_ready,
	output logic [7:0]           channel,
	output logic [31:0]          trig_time,
	output logic [15:0]          log_win,
	output logic [7:0]           phys_win,
	output logic [1:0]           info_flags,
	output logic [15:0]          packet_number,
	output logic [7:0]           sample_byte,
	output logic [IDX_W-1:0]     sample_index,
	output logic                 last
);

	byte_t win [PACKET_BYTES];
	byte_t nw [PACKET_BYTES];
	byte_t samples [SAMPLE_BYTES];
	logic  byte_fire;
	logic  busy;
	emit_t emit;
	hdr_t  hdr;

	assign byte_fire = byte_valid && byte_ready;

	for (genvar i = 0; i < PACKET_BYTES; i++) begin : g_win
		if (i < PACKET_BYTES - 1) begin : g_mid
			assign nw[i] = win[i+1];
		end else begin : g_end
			assign nw[i] = in_byte;
		end
		mfpp_cell u_cell (
			.clk     (clk),
			.ld      (1'b0),
			.ld_byte ('0),
			.sh      (byte_fire),
			.sh_byte (nw[i]),
			.q       (win[i])
		);
	end

	for (genvar k = 0; k < SAMPLE_BYTES; k++) begin : g_tap
		assign samples[k] = nw[SAMPLE_OFS+k];
	end

	mfpp_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wen    (cfg_wen),
		.cfg_idx    (cfg_idx),
		.cfg_wdata  (cfg_wdata),
		.byte_fire  (byte_fire),
		.nw         (nw),
		.busy       (busy),
		.byte_ready (byte_ready),
		.emit       (emit)
	);

	mfpp_out u_out (
		.clk          (clk),
		.arst_n       (arst_n),
		.emit         (emit),
		.samples      (samples),
		.result_ready (result_ready),
		.result_valid (result_valid),
		.busy         (busy),
		.hdr          (hdr),
		.sample_byte  (sample_byte),
		.sample_index (sample_index),
		.last         (last)
	);

	assign channel       = hdr.channel;
	assign trig_time     = hdr.trig_time;
	assign log_win       = hdr.log_win;
	assign phys_win      = hdr.phys_win;
	assign info_flags    = hdr.info_flags;
	assign packet_number = hdr.packet_number;

endmodule

`default_nettype wire
